/* sv/block_cache_slot_select_assert.svh */
// Assertion macros shared by the slot select RTL.
// Simulation builds get concurrent assertions; synthesis builds get nothing.
`ifndef BLOCK_CACHE_SLOT_SELECT_ASSERT_SVH
`define BLOCK_CACHE_SLOT_SELECT_ASSERT_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge outside reset.
`define BCSS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("block cache slot select: assertion failed");

// Check a property on every rising edge, reset included.
`define BCSS_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("block cache slot select: assertion failed");

`else

`define BCSS_ASSERT(label, clk, rst_n, prop)
`define BCSS_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

/* sv/bcss_pkg.sv */
package bcss_pkg;

    // Request kinds
    localparam logic CMD_READ = 1'b0;
    localparam logic CMD_ZERO = 1'b1;

    localparam int BLK_W  = 31;
    localparam int SLOT_W = 4;

    // Random generator: seed = seed * LCG_MUL + LCG_ADD, pick from seed >> LCG_SHIFT
    localparam int          SEED_W    = 64;
    localparam int          HALF_W    = SEED_W / 2;
    localparam int          LCG_SHIFT = 16;
    localparam int          LCG_QW    = SEED_W - LCG_SHIFT;
    localparam logic [31:0] LCG_MUL   = 32'd1103515245;
    localparam logic [63:0] LCG_ADD   = 64'd12345;

    // Modulo reduction: one byte of the shifted seed per step. A partial
    // dividend has 16 bits and the slot count fits in 8 bits, so a reciprocal
    // scaled by 2^24 gives the exact quotient digit.
    localparam int DIG_W      = 8;
    localparam int LCG_DIGITS = LCG_QW / DIG_W;
    localparam int LCG_CNT_W  = $clog2(LCG_DIGITS);
    localparam int RCP_SHIFT  = 3 * DIG_W;

    typedef struct packed {
        logic             cmd;
        logic [BLK_W-1:0] block_number;
    } req_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              hit;
        logic              load_from_disk;
        logic              clear_slot;
        logic              random_victim;
    } rsp_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RAND,
        S_DONE
    } sel_state_t;

    typedef enum logic [2:0] {
        L_IDLE,
        L_MUL_LO,
        L_MUL_HI,
        L_ADD,
        L_QUO,
        L_REM,
        L_DONE
    } lcg_state_t;

endpackage

/* sv/bcss_ram.sv */
module bcss_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one entry, read one entry with registered data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/bcss_lcg.sv */
`include "block_cache_slot_select_assert.svh"

module bcss_lcg #(
    parameter int SLOTS = 16,
    parameter int IDXW  = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            done,
    output logic [IDXW-1:0] victim
);

    import bcss_pkg::*;

    // Reciprocal of SLOTS, rounded up
    localparam logic [HALF_W-1:0] RCP_M =
        HALF_W'(((64'd1 << RCP_SHIFT) + 64'(SLOTS) - 64'd1) / 64'(SLOTS));

    lcg_state_t state_reg, state_next;

    logic [SEED_W-1:0]    seed_reg, seed_next;
    logic [SEED_W-1:0]    lo_reg, lo_next;
    logic [HALF_W-1:0]    hi_reg, hi_next;
    logic [LCG_QW-1:0]    quo_reg, quo_next;
    logic [DIG_W-1:0]     qdig_reg, qdig_next;
    logic [DIG_W-1:0]     rem_reg, rem_next;
    logic [LCG_CNT_W-1:0] cnt_reg, cnt_next;

    logic [HALF_W-1:0]  mul_a;
    logic [HALF_W-1:0]  mul_b;
    logic [SEED_W-1:0]  mul_p;
    logic [SEED_W-1:0]  seed_sum;
    logic [2*DIG_W-1:0] part;
    logic [2*DIG_W-1:0] part_rem;
    logic               last_digit;

    // Shared 32x32 multiplier: seed halves, then quotient digit, then digit times SLOTS
    always_comb
    begin
        case (state_reg)
            L_MUL_HI:
            begin
                mul_a = seed_reg[SEED_W-1:HALF_W];
                mul_b = LCG_MUL;
            end
            L_QUO:
            begin
                mul_a = HALF_W'(part);
                mul_b = RCP_M;
            end
            L_REM:
            begin
                mul_a = HALF_W'(qdig_reg);
                mul_b = HALF_W'(SLOTS);
            end
            default:
            begin
                mul_a = seed_reg[HALF_W-1:0];
                mul_b = LCG_MUL;
            end
        endcase
    end

    assign mul_p    = SEED_W'(mul_a) * SEED_W'(mul_b);
    assign seed_sum = lo_reg + {hi_reg, {HALF_W{1'b0}}} + LCG_ADD;

    // Partial dividend: running remainder with the next byte of the shifted seed
    assign part       = {rem_reg, quo_reg[LCG_QW-1 -: DIG_W]};
    assign part_rem   = part - mul_p[2*DIG_W-1:0];
    assign last_digit = (cnt_reg == LCG_CNT_W'(LCG_DIGITS - 1));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            L_IDLE:   if (start) state_next = L_MUL_LO;
            L_MUL_LO: state_next = L_MUL_HI;
            L_MUL_HI: state_next = L_ADD;
            L_ADD:    state_next = L_QUO;
            L_QUO:    state_next = L_REM;
            L_REM:    state_next = last_digit ? L_DONE : L_QUO;
            L_DONE:   state_next = L_IDLE;
            default:  state_next = L_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        done   = (state_reg == L_DONE);
        victim = rem_reg[IDXW-1:0];
    end

    // Datapath next values
    always_comb
    begin
        seed_next = seed_reg;
        lo_next   = lo_reg;
        hi_next   = hi_reg;
        quo_next  = quo_reg;
        qdig_next = qdig_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        case (state_reg)
            L_MUL_LO: lo_next = mul_p;
            L_MUL_HI: hi_next = mul_p[HALF_W-1:0];
            L_ADD:
            begin
                seed_next = seed_sum;
                quo_next  = seed_sum[SEED_W-1:LCG_SHIFT];
                rem_next  = '0;
                cnt_next  = '0;
            end
            L_QUO:    qdig_next = mul_p[RCP_SHIFT +: DIG_W];
            L_REM:
            begin
                rem_next = part_rem[DIG_W-1:0];
                quo_next = {quo_reg[LCG_QW-DIG_W-1:0], {DIG_W{1'b0}}};
                cnt_next = cnt_reg + 1'b1;
            end
            default: ;
        endcase
    end

    // Hold control state and the seed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            seed_reg  <= SEED_W'(1);
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            seed_reg  <= seed_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Hold partial products, the quotient digit and the remainder
    always_ff @(posedge clk)
    begin
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        quo_reg  <= quo_next;
        qdig_reg <= qdig_next;
        rem_reg  <= rem_next;
    end

    `BCSS_ASSERT(a_lcg_start_idle, clk, rst_n, start |-> state_reg == L_IDLE)
    `BCSS_ASSERT(a_lcg_done_pulse, clk, rst_n, done |=> !done)
    `BCSS_ASSERT(a_lcg_rem_range, clk, rst_n, (state_reg == L_DONE) |-> int'(rem_reg) < SLOTS)

endmodule

/* sv/block_cache_slot_select.sv */
// Slot selection for a fully associative block cache of SLOTS slots. A request
// beat carries a block number and a kind (read or zero-fill); the response beat
// names the slot that now holds the block and says whether it hit, whether the
// data must be loaded from disk or cleared, and whether the slot was a random
// victim. Tags sit in a single-port-read RAM that is scanned one slot per
// cycle and stops early on a hit; the response beat becomes valid and the next
// request can be taken from the same cycle on; when every slot is valid,
// the shared victim unit (one 32x32 multiplier that forms the new seed in two
// halves and then reduces it modulo SLOTS one byte at a time by reciprocal
// multiplication) picks the slot before the response is formed. One
// request is in flight at a time; a finished response waits in the output
// register while the next request is taken.
`include "block_cache_slot_select_assert.svh"

module block_cache_slot_select #(
    parameter int SLOTS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  bcss_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output bcss_pkg::rsp_t rsp
);

    import bcss_pkg::*;

    localparam int IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    sel_state_t state_reg, state_next;

    logic [IDXW:0]      cnt_reg, cnt_next;
    logic               cmp_vld_reg, cmp_vld_next;
    logic [IDXW-1:0]    cmp_idx_reg, cmp_idx_next;
    logic               free_found_reg, free_found_next;
    logic [IDXW-1:0]    free_idx_reg, free_idx_next;
    logic [IDXW-1:0]    chosen_reg, chosen_next;
    logic               hit_reg, hit_next;
    logic               rand_reg, rand_next;
    logic [SLOTS-1:0]   valid_reg, valid_next;
    req_t               req_reg, req_next;
    rsp_t               rsp_reg, rsp_next;
    logic               rsp_valid_reg, rsp_valid_next;

    logic             req_fire;
    logic             issue;
    logic             match;
    logic             last;
    logic             free_now;
    logic             rsp_load;
    logic             tag_we;
    logic [IDXW-1:0]  tag_raddr;
    logic [BLK_W-1:0] tag_rdata;
    logic             lcg_start;
    logic             lcg_done;
    logic [IDXW-1:0]  lcg_victim;

    bcss_ram #(
        .WIDTH (BLK_W),
        .DEPTH (SLOTS)
    ) u_tag_ram (
        .clk   (clk),
        .we    (tag_we),
        .waddr (chosen_reg),
        .wdata (req_reg.block_number),
        .raddr (tag_raddr),
        .rdata (tag_rdata)
    );

    bcss_lcg #(
        .SLOTS (SLOTS)
    ) u_lcg (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (lcg_start),
        .done   (lcg_done),
        .victim (lcg_victim)
    );

    // Scan status: the compare stage sees the tag read in the previous cycle
    assign req_fire = req_valid && req_ready;
    assign issue    = (cnt_reg < (IDXW+1)'(SLOTS));
    assign match    = cmp_vld_reg && valid_reg[cmp_idx_reg]
                      && (tag_rdata == req_reg.block_number);
    assign last     = cmp_vld_reg && (cmp_idx_reg == IDXW'(SLOTS - 1));
    assign free_now = cmp_vld_reg && !valid_reg[cmp_idx_reg];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire) state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (match)
                begin
                    state_next = S_DONE;
                end
                else if (last)
                begin
                    state_next = (free_found_reg || free_now) ? S_DONE : S_RAND;
                end
            end
            S_RAND:
            begin
                if (lcg_done) state_next = S_DONE;
            end
            S_DONE:
            begin
                if (rsp_load) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        req_ready = (state_reg == S_IDLE);
        tag_raddr = cnt_reg[IDXW-1:0];
        lcg_start = (state_reg == S_SCAN) && last && !match
                    && !free_found_reg && !free_now;
        rsp_load  = (state_reg == S_DONE) && (!rsp_valid_reg || rsp_ready);
        tag_we    = rsp_load && (!hit_reg || (req_reg.cmd == CMD_ZERO));
    end

    // Datapath next values
    always_comb
    begin
        cnt_next        = cnt_reg;
        cmp_vld_next    = cmp_vld_reg;
        cmp_idx_next    = cmp_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        chosen_next     = chosen_reg;
        hit_next        = hit_reg;
        rand_next       = rand_reg;
        valid_next      = valid_reg;
        req_next        = req_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg;

        // Drop the response once taken
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    req_next        = req;
                    cnt_next        = '0;
                    cmp_vld_next    = 1'b0;
                    free_found_next = 1'b0;
                end
            end
            S_SCAN:
            begin
                // Advance the read address, track the first free slot
                cnt_next     = issue ? cnt_reg + 1'b1 : cnt_reg;
                cmp_vld_next = issue;
                cmp_idx_next = cnt_reg[IDXW-1:0];
                if (free_now && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = cmp_idx_reg;
                end
                if (match)
                begin
                    chosen_next = cmp_idx_reg;
                    hit_next    = 1'b1;
                    rand_next   = 1'b0;
                end
                else if (last)
                begin
                    chosen_next = free_found_reg ? free_idx_reg : cmp_idx_reg;
                    hit_next    = 1'b0;
                    rand_next   = 1'b0;
                end
            end
            S_RAND:
            begin
                if (lcg_done)
                begin
                    chosen_next = lcg_victim;
                    hit_next    = 1'b0;
                    rand_next   = 1'b1;
                end
            end
            S_DONE:
            begin
                if (rsp_load)
                begin
                    valid_next[chosen_reg]  = 1'b1;
                    rsp_next.slot           = SLOT_W'(chosen_reg);
                    rsp_next.hit            = hit_reg;
                    rsp_next.load_from_disk = !hit_reg && (req_reg.cmd == CMD_READ);
                    rsp_next.clear_slot     = (req_reg.cmd == CMD_ZERO);
                    rsp_next.random_victim  = rand_reg;
                    rsp_valid_next          = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            cmp_vld_reg    <= 1'b0;
            free_found_reg <= 1'b0;
            valid_reg      <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            cmp_vld_reg    <= cmp_vld_next;
            free_found_reg <= free_found_next;
            valid_reg      <= valid_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        cmp_idx_reg  <= cmp_idx_next;
        free_idx_reg <= free_idx_next;
        chosen_reg   <= chosen_next;
        hit_reg      <= hit_next;
        rand_reg     <= rand_next;
        req_reg      <= req_next;
        rsp_reg      <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `BCSS_ASSERT(a_rand_only_when_full, clk, rst_n, lcg_start |-> (&valid_reg))
    `BCSS_ASSERT(a_lcg_done_in_rand, clk, rst_n, lcg_done |-> state_reg == S_RAND)
    `BCSS_ASSERT(a_slot_marked_valid, clk, rst_n, rsp_load |=> valid_reg[$past(chosen_reg)])
    `BCSS_ASSERT_ALWAYS(a_hit_not_random, clk, (rsp_valid && rsp.hit) |-> !rsp.random_victim)

endmodule
